>>> hdl/wavp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WAV header parser package
// Field widths, status and format codes, header ids and format mapping.
// ----------------------------------------------------------------------------
package wavp_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LEN_W    = 33;
  localparam int unsigned STATUS_W = 4;
  localparam int unsigned HALF_W   = 16;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned FORMAT_W = 2;

  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [FORMAT_W-1:0] format_t;
  typedef logic [LEN_W-1:0]    len_t;

  localparam status_t ST_OK        = 4'd0;
  localparam status_t ST_TOO_SMALL = 4'd1;
  localparam status_t ST_RIFF      = 4'd2;
  localparam status_t ST_CHUNK     = 4'd3;
  localparam status_t ST_WAVE      = 4'd4;
  localparam status_t ST_FMT       = 4'd5;
  localparam status_t ST_SUB1      = 4'd6;
  localparam status_t ST_DATA_ID   = 4'd7;
  localparam status_t ST_SUB2      = 4'd8;

  localparam format_t FMT_INT16   = 2'd0;
  localparam format_t FMT_FLOAT32 = 2'd1;
  localparam format_t FMT_CUSTOM  = 2'd2;

  localparam logic [WORD_W-1:0] ID_RIFF = 32'h4646_4952;
  localparam logic [WORD_W-1:0] ID_WAVE = 32'h4556_4157;
  localparam logic [WORD_W-1:0] ID_FMT  = 32'h2074_6D66;
  localparam logic [WORD_W-1:0] ID_DATA = 32'h6174_6164;

  localparam logic [HALF_W-1:0] TAG_PCM   = 16'd1;
  localparam logic [HALF_W-1:0] TAG_FLOAT = 16'd3;

  localparam len_t MIN_LEN = 33'd44;
  localparam len_t POS_MAX = {LEN_W{1'b1}};

  function automatic format_t map_format(input logic [HALF_W-1:0] tag,
                                         input logic [HALF_W-1:0] bits);
    format_t f;
    f = FMT_CUSTOM;
    if (tag == TAG_PCM && bits == 16'd16) f = FMT_INT16;
    else if (tag == TAG_FLOAT && bits == 16'd32) f = FMT_FLOAT32;
    return f;
  endfunction

endpackage

>>> hdl/wavp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WAV header parser channels
// Valid/ready channels for file bytes in and status requests out.
// ----------------------------------------------------------------------------
interface wavp_in_if;
  import wavp_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic [LEN_W-1:0]  file_length;
  logic              first_byte;

  modport source (output valid, data_byte, file_length, first_byte, input ready);
  modport sink   (input valid, data_byte, file_length, first_byte, output ready);
endinterface

interface wavp_out_if;
  import wavp_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [HALF_W-1:0]   num_channels;
  logic [WORD_W-1:0]   sample_rate;
  logic [HALF_W-1:0]   bits_per_sample;
  logic [FORMAT_W-1:0] sample_format;
  logic [LEN_W-1:0]    data_offset;
  logic [WORD_W-1:0]   data_size;

  modport source (output valid, status, num_channels, sample_rate, bits_per_sample,
                  sample_format, data_offset, data_size, input ready);
  modport sink   (input valid, status, num_channels, sample_rate, bits_per_sample,
                  sample_format, data_offset, data_size, output ready);
endinterface

>>> hdl/wav_header_stream_parser.sv
`timescale 1ns / 1ps
// Bytes pass the input register; a status request then waits in the result register.
// Throughput: one byte per cycle unless the result side stalls; set by the single parse
// stage between input and result registers, which updates the parser state every byte.
// Reset (rst_n low, synchronous) empties both registers and returns the parser to
// offset zero expecting RIFF; first_byte restarts it the same way.
// ----------------------------------------------------------------------------
// WAV header stream parser
// Checks a RIFF/WAVE header byte by byte and reports one status per file.
// ----------------------------------------------------------------------------
module wav_header_stream_parser (
  input  logic        clk,
  input  logic        rst_n,
  wavp_in_if.sink     in_chan,
  wavp_out_if.source  out_chan
);
  import wavp_pkg::*;

  typedef enum logic [7:0] {
    PH_RIFF      = 8'b0000_0001,
    PH_SIZE      = 8'b0000_0010,
    PH_WAVE      = 8'b0000_0100,
    PH_SCAN_FMT  = 8'b0000_1000,
    PH_SUB1      = 8'b0001_0000,
    PH_FIELDS    = 8'b0010_0000,
    PH_SCAN_DATA = 8'b0100_0000,
    PH_SUB2      = 8'b1000_0000
  } phase_t;

  // input register
  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;
  len_t              s1_len_r;
  logic              s1_first_r;

  // parser state
  len_t              pos_r, pos_nxt;
  phase_t            phase_r, phase_nxt;
  logic [WORD_W-1:0] win_r, win_nxt;
  logic [WORD_W-1:0] riff_size_r, riff_size_nxt;
  len_t              fmt_pos_r, fmt_pos_nxt;
  len_t              data_pos_r, data_pos_nxt;
  logic [HALF_W-1:0] tag_r, tag_nxt;
  logic [HALF_W-1:0] chan_r, chan_nxt;
  logic [WORD_W-1:0] rate_r, rate_nxt;
  logic [HALF_W-1:0] bits_r, bits_nxt;
  logic              decided_r, decided_nxt;

  // result register
  logic              out_valid_r;
  status_t           out_status_r;
  logic [HALF_W-1:0] out_chan_r;
  logic [WORD_W-1:0] out_rate_r;
  logic [HALF_W-1:0] out_bits_r;
  format_t           out_format_r;
  len_t              out_offset_r;
  logic [WORD_W-1:0] out_size_r;

  logic              advance;
  logic              hit;
  status_t           status;
  len_t              doff;
  logic [WORD_W-1:0] dsize;

  // working values of the step
  len_t              p;
  phase_t            ph;
  logic              dec;
  logic [WORD_W-1:0] win;
  logic [LEN_W:0]    len_x, p_x, fmt7, data7;
  len_t              fmt_off, i_pos;
  logic [LEN_W+1:0]  base, base2, base3, nxt_start, data_end, len_w;
  logic              fmt_read;

  assign advance       = !out_valid_r || out_chan.ready;
  assign in_chan.ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
    if (in_chan.ready && in_chan.valid) begin
      s1_byte_r  <= in_chan.data_byte;
      s1_len_r   <= in_chan.file_length;
      s1_first_r <= in_chan.first_byte;
    end
  end

  always_comb begin
    // start from reset values when a new file begins
    if (s1_first_r) begin
      p = '0; ph = PH_RIFF; win = '0; dec = 1'b0;
      riff_size_nxt = '0; fmt_pos_nxt = '0; data_pos_nxt = '0;
      tag_nxt = '0; chan_nxt = '0; rate_nxt = '0; bits_nxt = '0;
    end else begin
      p = pos_r; ph = phase_r; win = win_r; dec = decided_r;
      riff_size_nxt = riff_size_r; fmt_pos_nxt = fmt_pos_r; data_pos_nxt = data_pos_r;
      tag_nxt = tag_r; chan_nxt = chan_r; rate_nxt = rate_r; bits_nxt = bits_r;
    end
    pos_nxt     = (p == POS_MAX) ? p : p + 33'd1;
    phase_nxt   = ph;
    decided_nxt = dec;
    win_nxt     = win;
    hit         = 1'b0;
    status      = ST_OK;
    doff        = '0;
    dsize       = '0;

    len_x     = {1'b0, s1_len_r};
    len_w     = {2'b00, s1_len_r};
    p_x       = {1'b0, p};
    i_pos     = p - 33'd3;
    fmt7      = {1'b0, fmt_pos_r} + 34'd7;
    data7     = {1'b0, data_pos_r} + 34'd7;
    fmt_off   = p - fmt_pos_r;
    base      = {2'b00, fmt_pos_r} + 35'd24;
    base2     = base + 35'd2;
    base3     = base + 35'd3;
    nxt_start = ({2'b00, p} >= base2) ? {2'b00, p} - 35'd2 : base;
    data_end  = {3'b000, win_nxt} + 35'd8 + {2'b00, data_pos_r};

    if (!dec) begin
      win_nxt = {s1_byte_r, win[WORD_W-1:BYTE_W]};
      data_end = {3'b000, win_nxt} + 35'd8 + {2'b00, data_pos_r};
      if (p == '0 && s1_len_r < MIN_LEN) begin
        hit = 1'b1; status = ST_TOO_SMALL;
      end else begin
        case (ph)
          PH_RIFF: begin
            if (p == 33'd3) begin
              if (win_nxt != ID_RIFF) begin hit = 1'b1; status = ST_RIFF; end
              else phase_nxt = PH_SIZE;
            end
          end
          PH_SIZE: begin
            if (p == 33'd7) begin
              riff_size_nxt = win_nxt;
              if ({1'b0, win_nxt} + 33'd8 != s1_len_r) begin
                hit = 1'b1; status = ST_CHUNK;
              end else phase_nxt = PH_WAVE;
            end
          end
          PH_WAVE: begin
            if (p == 33'd11) begin
              if (win_nxt != ID_WAVE) begin hit = 1'b1; status = ST_WAVE; end
              else phase_nxt = PH_SCAN_FMT;
            end
          end
          PH_SCAN_FMT: begin
            if (p >= 33'd15) begin
              if (win_nxt == ID_FMT && ({1'b0, i_pos} + 34'd24) < len_x) begin
                fmt_pos_nxt = i_pos; phase_nxt = PH_SUB1;
              end else if (({1'b0, i_pos} + 34'd25) >= len_x) begin
                hit = 1'b1; status = ST_FMT;
              end
            end
          end
          PH_SUB1: begin
            if (p_x == fmt7) begin
              if (win_nxt >= riff_size_r) begin hit = 1'b1; status = ST_SUB1; end
              else phase_nxt = PH_FIELDS;
            end
          end
          PH_FIELDS: begin
            if (fmt_off == 33'd9) tag_nxt = win_nxt[WORD_W-1:HALF_W];
            else if (fmt_off == 33'd11) chan_nxt = win_nxt[WORD_W-1:HALF_W];
            else if (fmt_off == 33'd15) rate_nxt = win_nxt;
            else if (fmt_off == 33'd23) begin
              bits_nxt = win_nxt[WORD_W-1:HALF_W]; phase_nxt = PH_SCAN_DATA;
            end
          end
          PH_SCAN_DATA: begin
            if ({2'b00, p} >= base3 && win_nxt == ID_DATA &&
                ({1'b0, i_pos} + 34'd8) < len_x) begin
              data_pos_nxt = i_pos; phase_nxt = PH_SUB2;
            end else if (nxt_start + 35'd8 >= len_w) begin
              hit = 1'b1; status = ST_DATA_ID;
            end
          end
          PH_SUB2: begin
            if (p_x == data7) begin
              hit   = 1'b1;
              dsize = win_nxt;
              if (data_end > len_w) status = ST_SUB2;
              else begin
                status = ST_OK;
                doff   = data_pos_r + 33'd8;
              end
            end
          end
          default: begin
            phase_nxt = ph;
          end
        endcase
      end
      if (hit) decided_nxt = 1'b1;
    end
    fmt_read = (status == ST_OK) || (status >= ST_DATA_ID);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      phase_r     <= PH_RIFF;
      win_r       <= '0;
      riff_size_r <= '0;
      fmt_pos_r   <= '0;
      data_pos_r  <= '0;
      tag_r       <= '0;
      chan_r      <= '0;
      rate_r      <= '0;
      bits_r      <= '0;
      decided_r   <= 1'b0;
    end else if (s1_valid_r && advance) begin
      pos_r       <= pos_nxt;
      phase_r     <= phase_nxt;
      win_r       <= win_nxt;
      riff_size_r <= riff_size_nxt;
      fmt_pos_r   <= fmt_pos_nxt;
      data_pos_r  <= data_pos_nxt;
      tag_r       <= tag_nxt;
      chan_r      <= chan_nxt;
      rate_r      <= rate_nxt;
      bits_r      <= bits_nxt;
      decided_r   <= decided_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r && hit;
    end
    // fmt fields come from the held values, not this byte's updates
    if (advance && s1_valid_r && hit) begin
      out_status_r <= status;
      out_chan_r   <= fmt_read ? (s1_first_r ? '0 : chan_r) : '0;
      out_rate_r   <= fmt_read ? (s1_first_r ? '0 : rate_r) : '0;
      out_bits_r   <= fmt_read ? (s1_first_r ? '0 : bits_r) : '0;
      out_format_r <= fmt_read ? map_format(s1_first_r ? '0 : tag_r,
                                            s1_first_r ? '0 : bits_r)
                               : FMT_CUSTOM;
      out_offset_r <= doff;
      out_size_r   <= dsize;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.status          = out_status_r;
  assign out_chan.num_channels    = out_chan_r;
  assign out_chan.sample_rate     = out_rate_r;
  assign out_chan.bits_per_sample = out_bits_r;
  assign out_chan.sample_format   = out_format_r;
  assign out_chan.data_offset     = out_offset_r;
  assign out_chan.data_size       = out_size_r;

endmodule

>>> tb/wavp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WAV header parser checker
// Watches both channels, predicts the status request of every file from the accepted
// bytes and compares each returned request field by field, oldest first.
// ----------------------------------------------------------------------------
module wavp_checker (
  input  logic clk,
  input  logic rst_n,
  wavp_in_if   in_chan,
  wavp_out_if  out_chan,
  output int   fail_count,
  output int   awaited_count
);
  import wavp_pkg::*;

  typedef enum logic [3:0] {
    PH_RIFF_ID, PH_CHUNK_SIZE, PH_WAVE_ID, PH_FMT_SCAN,
    PH_SUB1_SIZE, PH_FMT_FIELDS, PH_DATA_SCAN, PH_SUB2_SIZE
  } parse_phase_t;

  typedef struct packed {
    status_t             status;
    logic [HALF_W-1:0]   chans;
    logic [WORD_W-1:0]   rate;
    logic [HALF_W-1:0]   bits;
    format_t             fmt;
    len_t                offset;
    logic [WORD_W-1:0]   data_sz;
  } status_rec_t;

  // parser copy
  len_t              file_pos;
  parse_phase_t      phase;
  logic [WORD_W-1:0] win;
  logic [WORD_W-1:0] chunk_sz;
  len_t              fmt_at;
  len_t              data_at;
  logic [HALF_W-1:0] tag_q;
  logic [HALF_W-1:0] chans_q;
  logic [WORD_W-1:0] rate_q;
  logic [HALF_W-1:0] bits_q;
  logic              settled;

  status_rec_t status_q[$];
  int          mismatches = 0;

  function automatic void clear_parser();
    file_pos = '0;
    phase    = PH_RIFF_ID;
    win      = '0;
    chunk_sz = '0;
    fmt_at   = '0;
    data_at  = '0;
    tag_q    = '0;
    chans_q  = '0;
    rate_q   = '0;
    bits_q   = '0;
    settled  = 1'b0;
  endfunction

  // Advance the parser by one byte; return 1 when this byte decides the file.
  function automatic bit parse_byte(input logic [BYTE_W-1:0] b, input len_t len,
                                    input logic first, output status_rec_t rec);
    longint unsigned   p;
    longint unsigned   l;
    longint unsigned   base;
    longint unsigned   nxt;
    longint unsigned   off;
    status_t           st;
    bit                hit;
    bit                fmt_seen;
    len_t              doff;
    logic [WORD_W-1:0] dsize;
    rec   = '0;
    st    = ST_OK;
    hit   = 1'b0;
    doff  = '0;
    dsize = '0;
    if (first) clear_parser();
    p = file_pos;
    l = len;
    if (file_pos != POS_MAX) file_pos = file_pos + 1'b1;
    if (settled) return 1'b0;
    win = {b, win[WORD_W-1:BYTE_W]};
    if (p == 0 && l < MIN_LEN) begin
      hit = 1'b1;
      st  = ST_TOO_SMALL;
    end else begin
      case (phase)
        PH_RIFF_ID: begin
          if (p == 3) begin
            if (win != ID_RIFF) begin
              hit = 1'b1;
              st  = ST_RIFF;
            end else begin
              phase = PH_CHUNK_SIZE;
            end
          end
        end
        PH_CHUNK_SIZE: begin
          if (p == 7) begin
            chunk_sz = win;
            if (64'(chunk_sz) + 8 != l) begin
              hit = 1'b1;
              st  = ST_CHUNK;
            end else begin
              phase = PH_WAVE_ID;
            end
          end
        end
        PH_WAVE_ID: begin
          if (p == 11) begin
            if (win != ID_WAVE) begin
              hit = 1'b1;
              st  = ST_WAVE;
            end else begin
              phase = PH_FMT_SCAN;
            end
          end
        end
        PH_FMT_SCAN: begin
          // window holds bytes p-3..p; take the first qualifying start
          if (p >= 15) begin
            if (win == ID_FMT && (p - 3) + 24 < l) begin
              fmt_at = len_t'(p - 3);
              phase  = PH_SUB1_SIZE;
            end else if ((p - 3) + 25 >= l) begin
              hit = 1'b1;
              st  = ST_FMT;
            end
          end
        end
        PH_SUB1_SIZE: begin
          if (p == 64'(fmt_at) + 7) begin
            if (win >= chunk_sz) begin
              hit = 1'b1;
              st  = ST_SUB1;
            end else begin
              phase = PH_FMT_FIELDS;
            end
          end
        end
        PH_FMT_FIELDS: begin
          off = p - fmt_at;
          if (off == 9) tag_q = win[WORD_W-1:HALF_W];
          else if (off == 11) chans_q = win[WORD_W-1:HALF_W];
          else if (off == 15) rate_q = win;
          else if (off == 23) begin
            bits_q = win[WORD_W-1:HALF_W];
            phase  = PH_DATA_SCAN;
          end
        end
        PH_DATA_SCAN: begin
          base = 64'(fmt_at) + 24;
          nxt  = (p >= base + 2) ? p - 2 : base;
          if (p >= base + 3 && win == ID_DATA && (p - 3) + 8 < l) begin
            data_at = len_t'(p - 3);
            phase   = PH_SUB2_SIZE;
          end else if (nxt + 8 >= l) begin
            hit = 1'b1;
            st  = ST_DATA_ID;
          end
        end
        default: begin
          if (p == 64'(data_at) + 7) begin
            hit   = 1'b1;
            dsize = win;
            if (64'(dsize) + 8 + 64'(data_at) > l) begin
              st = ST_SUB2;
            end else begin
              st   = ST_OK;
              doff = data_at + 33'd8;
            end
          end
        end
      endcase
    end
    if (!hit) return 1'b0;
    settled    = 1'b1;
    fmt_seen   = (st == ST_OK) || (st >= ST_DATA_ID);
    rec.status = st;
    rec.chans  = fmt_seen ? chans_q : '0;
    rec.rate   = fmt_seen ? rate_q : '0;
    rec.bits   = fmt_seen ? bits_q : '0;
    if (fmt_seen && tag_q == TAG_PCM && bits_q == 16'd16) rec.fmt = FMT_INT16;
    else if (fmt_seen && tag_q == TAG_FLOAT && bits_q == 16'd32) rec.fmt = FMT_FLOAT32;
    else rec.fmt = FMT_CUSTOM;
    rec.offset  = doff;
    rec.data_sz = (st == ST_OK || st == ST_SUB2) ? dsize : '0;
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want_v,
                             input logic [63:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    status_rec_t want;
    status_rec_t got;
    if (!rst_n) begin
      clear_parser();
      status_q.delete();
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        if (parse_byte(in_chan.data_byte, in_chan.file_length, in_chan.first_byte, want))
          status_q.push_back(want);
      end
      if (out_chan.valid && out_chan.ready) begin
        got.status  = out_chan.status;
        got.chans   = out_chan.num_channels;
        got.rate    = out_chan.sample_rate;
        got.bits    = out_chan.bits_per_sample;
        got.fmt     = out_chan.sample_format;
        got.offset  = out_chan.data_offset;
        got.data_sz = out_chan.data_size;
        if (status_q.size() == 0) begin
          $error("status request 0x%0h arrived with none expected", got.status);
          mismatches++;
        end else begin
          want = status_q.pop_front();
          check_field("status", want.status, got.status);
          check_field("num_channels", want.chans, got.chans);
          check_field("sample_rate", want.rate, got.rate);
          check_field("bits_per_sample", want.bits, got.bits);
          check_field("sample_format", want.fmt, got.fmt);
          check_field("data_offset", want.offset, got.offset);
          check_field("data_size", want.data_sz, got.data_sz);
        end
      end
    end
    fail_count    <= mismatches;
    awaited_count <= status_q.size();
  end

endmodule

>>> tb/tb_wav_header_stream_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WAV header parser testbench
// Feeds directed and random WAV headers, well-formed and broken, byte by byte
// under varying idle and stall patterns; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_wav_header_stream_parser;
  import wavp_pkg::*;

  localparam len_t LEN_TOP     = 33'h1_0000_0007;
  localparam int   QUIET_LIMIT = 2000;
  localparam int   HOLD_CYCLES = 400;
  localparam int   ITEM_GOAL   = 1450;

  typedef enum int {
    FK_OK, FK_SMALL, FK_RIFF, FK_CHUNK, FK_WAVE, FK_NO_FMT,
    FK_SUB1, FK_NO_DATA, FK_SUB2, FK_NOISE
  } file_kind_t;

  logic clk = 1'b0;
  logic rst_n;

  wavp_in_if  in_chan();
  wavp_out_if out_chan();

  int fails;
  int awaited;

  int  sent_items = 0;
  int  idle_pct   = 0;
  int  stall_pct  = 0;
  bit  hold_req   = 1'b0;
  int  quiet_cycles = 0;

  logic [BYTE_W-1:0] file_bytes[$];
  len_t              file_len;

  wav_header_stream_parser dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  wavp_checker status_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_chan       (in_chan),
    .out_chan      (out_chan),
    .fail_count    (fails),
    .awaited_count (awaited)
  );

  always #5 clk = ~clk;

  // no forward progress on either channel for too long
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin : sink_side
    int hold_left;
    hold_left      = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  task automatic send_req(input logic [BYTE_W-1:0] b, input len_t len, input logic first);
    case ((sent_items / 120) % 4)
      0: begin
        idle_pct  = 0;
        stall_pct = 0;
      end
      1: begin
        idle_pct  = 47;
        stall_pct = 0;
      end
      2: begin
        idle_pct  = 0;
        stall_pct = 47;
      end
      default: begin
        idle_pct  = 8;
        stall_pct = 8;
      end
    endcase
    if (sent_items == 700) hold_req = 1'b1;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.data_byte   <= b;
    in_chan.file_length <= len;
    in_chan.first_byte  <= first;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    sent_items++;
  endtask

  task automatic send_file(input logic mark_first);
    foreach (file_bytes[k]) send_req(file_bytes[k], file_len, (k == 0) ? mark_first : 1'b0);
  endtask

  task automatic put_word(input logic [WORD_W-1:0] w);
    for (int k = 0; k < 4; k++) file_bytes.push_back(w[8*k +: 8]);
  endtask

  task automatic put_half(input logic [HALF_W-1:0] h);
    file_bytes.push_back(h[7:0]);
    file_bytes.push_back(h[15:8]);
  endtask

  task automatic put_junk(input int n);
    repeat (n) file_bytes.push_back(8'($urandom));
  endtask

  task automatic place_word(input int at, input logic [WORD_W-1:0] w);
    for (int k = 0; k < 4; k++) file_bytes[at + k] = w[8*k +: 8];
  endtask

  // Build one header of the given kind into file_bytes / file_len.
  task automatic build_wav(input file_kind_t kind);
    int                junk_a;
    int                junk_b;
    int                fmt_end;
    int                hdr_end;
    longint unsigned   room;
    longint unsigned   cap;
    longint unsigned   over;
    logic [WORD_W-1:0] riff_sz;
    logic [WORD_W-1:0] sub1_sz;
    logic [WORD_W-1:0] dsize;
    logic [HALF_W-1:0] tag;
    logic [HALF_W-1:0] bits;
    file_bytes.delete();
    junk_a  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 24) : 0;
    junk_b  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
    fmt_end = 36 + junk_a;
    hdr_end = fmt_end + junk_b + 8;
    case (kind)
      FK_NO_FMT:  file_len = len_t'(44 + $urandom_range(0, 40));
      FK_NO_DATA: file_len = len_t'(fmt_end + $urandom_range(8, 40));
      default: begin
        case ($urandom_range(0, 3))
          0: file_len = len_t'(hdr_end + $urandom_range(0, 1));
          1: file_len = len_t'(hdr_end + $urandom_range(0, 5000));
          2: file_len = {1'b0, $urandom()};
          default: file_len = LEN_TOP - $urandom_range(0, 15);
        endcase
      end
    endcase
    if (file_len < MIN_LEN) file_len = MIN_LEN;
    if (kind != FK_NO_FMT && kind != FK_NO_DATA && file_len < hdr_end)
      file_len = len_t'(hdr_end);
    riff_sz = WORD_W'(file_len - 8);

    put_word(ID_RIFF);
    put_word(riff_sz);
    put_word(ID_WAVE);
    if (kind == FK_NO_FMT) begin
      put_junk(int'(file_len) - 12);
      // sometimes a fmt id that starts too late to qualify
      if ($urandom_range(0, 1))
        place_word($urandom_range(int'(file_len) - 24, int'(file_len) - 4), ID_FMT);
    end else begin
      case ($urandom_range(0, 4))
        0: begin
          tag  = TAG_PCM;
          bits = 16'd16;
        end
        1: begin
          tag  = TAG_FLOAT;
          bits = 16'd32;
        end
        2: begin
          tag  = TAG_PCM;
          bits = 16'd32;
        end
        3: begin
          tag  = TAG_FLOAT;
          bits = 16'd16;
        end
        default: begin
          tag  = 16'($urandom);
          bits = 16'($urandom);
        end
      endcase
      if (kind == FK_SUB1)
        sub1_sz = $urandom_range(0, 1) ? riff_sz
                                       : riff_sz + $urandom_range(0, 32'hFFFF_FFFF - riff_sz);
      else
        sub1_sz = $urandom_range(0, 1) ? 32'd16 : $urandom_range(0, riff_sz - 1);
      put_junk(junk_a);
      put_word(ID_FMT);
      put_word(sub1_sz);
      put_half(tag);
      put_half(16'($urandom));
      put_word($urandom());
      put_word($urandom());
      put_half(16'($urandom));
      put_half(bits);
      if (kind == FK_NO_DATA) begin
        put_junk(int'(file_len) - fmt_end);
        // sometimes a data id with no room left behind it
        if ($urandom_range(0, 1))
          place_word($urandom_range(int'(file_len) - 8, int'(file_len) - 4), ID_DATA);
      end else begin
        room = file_len - hdr_end;
        cap  = (room > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : room;
        if (kind == FK_SUB2) begin
          over  = room + 1 + $urandom_range(0, 99);
          dsize = (over > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : WORD_W'(over);
        end else begin
          case ($urandom_range(0, 2))
            0: dsize = WORD_W'(cap);
            1: dsize = '0;
            default: dsize = $urandom_range(0, WORD_W'(cap));
          endcase
        end
        put_junk(junk_b);
        put_word(ID_DATA);
        put_word(dsize);
      end
    end
    case (kind)
      FK_RIFF:  file_bytes[$urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
      FK_CHUNK: file_bytes[4 + $urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
      FK_WAVE:  file_bytes[8 + $urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
      default: ;
    endcase
    // trailing bytes after the decision are ignored by the block
    put_junk($urandom_range(0, 3));
  endtask

  task automatic send_noise();
    int   n;
    len_t len;
    n   = $urandom_range(1, 40);
    len = {1'($urandom_range(0, 1)), $urandom()};
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 7) == 0) len = {1'($urandom_range(0, 1)), $urandom()};
      send_req(8'($urandom), len, (k == 0) ? 1'b1 : ($urandom_range(0, 9) == 0));
    end
  endtask

  initial begin : stimulus
    int         pick;
    file_kind_t kind;
    rst_n               = 1'b0;
    in_chan.valid       = 1'b0;
    in_chan.data_byte   = '0;
    in_chan.file_length = '0;
    in_chan.first_byte  = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // too small right after reset, without first_byte
    file_bytes = '{8'h00};
    file_len   = 33'd43;
    send_file(1'b0);
    // zero length, all-ones byte
    file_bytes = '{8'hFF};
    file_len   = '0;
    send_file(1'b1);
    // bad RIFF id at the largest length
    file_bytes.delete();
    put_word(ID_RIFF ^ 32'h0A00_0000);
    file_len = POS_MAX;
    send_file(1'b1);
    // chunk size zero against the minimum length
    file_bytes.delete();
    put_word(ID_RIFF);
    put_word('0);
    file_len = MIN_LEN;
    send_file(1'b1);
    // largest chunk size, bad WAVE id
    file_bytes.delete();
    put_word(ID_RIFF);
    put_word('1);
    put_word(ID_WAVE ^ 32'h0100_0000);
    file_len = LEN_TOP;
    send_file(1'b1);

    while (sent_items < ITEM_GOAL) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) kind = FK_OK;
      else if (pick < 52) kind = FK_SMALL;
      else if (pick < 58) kind = FK_RIFF;
      else if (pick < 64) kind = FK_CHUNK;
      else if (pick < 70) kind = FK_WAVE;
      else if (pick < 76) kind = FK_NO_FMT;
      else if (pick < 82) kind = FK_SUB1;
      else if (pick < 88) kind = FK_NO_DATA;
      else if (pick < 94) kind = FK_SUB2;
      else kind = FK_NOISE;
      if (kind == FK_NOISE) begin
        send_noise();
      end else if (kind == FK_SMALL) begin
        file_bytes.delete();
        put_junk($urandom_range(1, 4));
        file_len = len_t'($urandom_range(0, 43));
        send_file(1'b1);
      end else begin
        build_wav(kind);
        send_file(1'b1);
      end
    end
    in_chan.valid <= 1'b0;

    // let the checker see the last accept before trusting its count
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (awaited != 0) $error("%0d status requests never arrived", awaited);
    if (fails == 0 && awaited == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
